/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shorthand for clocked concurrent assertions on aclk / aresetn
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/pidpi_pkg.sv */
// ----------------------------------------------------------------------------
// pidpi_pkg
// Shared types and constants of the positional / incremental PID unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pidpi_pkg;

    // fixed field widths
    localparam int GAIN_WIDTH     = 16;
    localparam int LIMIT_WIDTH    = 31;
    localparam int THRESH_WIDTH   = 17;
    localparam int DRIVE_WIDTH    = 32;
    localparam int CFG_DATA_WIDTH = 32;
    localparam int CFG_IDX_WIDTH  = 3;

    // configuration register map
    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_GAIN_P          = 3'd0,
        CFG_GAIN_I          = 3'd1,
        CFG_GAIN_D          = 3'd2,
        CFG_OUTPUT_LIMIT    = 3'd3,
        CFG_INTEGRAL_LIMIT  = 3'd4,
        CFG_SEPARATION_ON   = 3'd5,
        CFG_SEPARATION_THR  = 3'd6,
        CFG_INCREMENTAL     = 3'd7
    } cfg_idx_t;

    // item function codes carried on tuser
    typedef enum logic {
        FUNC_STEP  = 1'b0,
        FUNC_CLEAR = 1'b1
    } func_t;

endpackage

`default_nettype wire

/* rtl/core/pid_position_incremental_unit.sv */
// ----------------------------------------------------------------------------
// pid_position_incremental_unit
// PID controller step, positional or incremental form, Q8.8 gains
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one beat per control sample. s_tdata holds setpoint and
//   measured, s_tuser selects a control step (0) or a clear of the error
//   history and integral (1). m_ channel: one beat per sample, m_tdata holds
//   the drive (positional output or incremental delta, zero after a clear).
//   cfg channel: gains, limits, separation and mode, written while idle.
// Pipeline: an accepted s_ beat goes through the input register, then one
//   pass of subtract, integral clamp, three multipliers, sum, shift and
//   output clamp into the result register, which drives m_tvalid.
// Throughput: one sample per cycle unless m_tready stalls. The error
//   history and integral are updated in the same pass that loads the result
//   register, so the next sample sees them in the following cycle.
// Stall: when m_tready is low the result holds, the input register fills,
//   and s_tready drops only when both stages are full.
// Reset: aresetn low clears all configuration registers, the error history,
//   the integral and both stage valids. cfg_ready is always high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pid_position_incremental_unit #(
    parameter int SAMPLE_WIDTH   = 16,
    parameter int GAIN_FRAC_BITS = 8
) (
    input  wire logic                                     aclk,
    input  wire logic                                     aresetn,
    // input samples
    input  wire logic                                     s_tvalid,
    output logic                                          s_tready,
    // [SAMPLE_WIDTH-1:0] setpoint, [2*SAMPLE_WIDTH-1:SAMPLE_WIDTH] measured
    input  wire logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]      s_tdata,
    // [0] func
    input  wire logic                                     s_tuser,
    // results
    output logic                                          m_tvalid,
    input  wire logic                                     m_tready,
    // [31:0] drive
    output logic [pidpi_pkg::DRIVE_WIDTH-1:0]             m_tdata,
    // configuration writes
    input  wire logic                                     cfg_valid,
    output logic                                          cfg_ready,
    input  wire logic [pidpi_pkg::CFG_IDX_WIDTH-1:0]      cfg_index,
    input  wire logic [pidpi_pkg::CFG_DATA_WIDTH-1:0]     cfg_data
);

    localparam int SW   = SAMPLE_WIDTH;
    localparam int EW   = SW + 1;                       // error
    localparam int DW   = SW + 2;                       // first difference
    localparam int D2W  = SW + 3;                       // second difference
    localparam int SUMW = 32;                           // integral
    localparam int OPW  = (D2W > SUMW) ? D2W : SUMW;    // multiplier operand
    localparam int PW   = OPW + pidpi_pkg::GAIN_WIDTH;  // product
    localparam int ACCW = PW + 2;                       // sum of three products
    localparam int CW   = (EW > pidpi_pkg::THRESH_WIDTH) ? EW : pidpi_pkg::THRESH_WIDTH;

    // configuration registers
    logic signed [pidpi_pkg::GAIN_WIDTH-1:0]   gain_p_reg, gain_i_reg, gain_d_reg;
    logic [pidpi_pkg::LIMIT_WIDTH-1:0]         output_limit_reg, integral_limit_reg;
    logic                                      separation_on_reg;
    logic [pidpi_pkg::THRESH_WIDTH-1:0]        separation_thr_reg;
    logic                                      incremental_reg;

    // controller state
    logic signed [EW-1:0]   last_err_reg, last_err_next;
    logic signed [EW-1:0]   older_err_reg, older_err_next;
    logic signed [SUMW-1:0] err_sum_reg, err_sum_next;

    // pipeline registers
    logic                   in_valid_reg;
    logic                   in_func_reg;
    logic signed [SW-1:0]   in_setpoint_reg, in_measured_reg;
    logic                   out_valid_reg;
    logic [pidpi_pkg::DRIVE_WIDTH-1:0] drive_reg, drive_next;

    logic out_free;
    logic advance;

    // handshakes
    assign out_free  = !out_valid_reg || m_tready;
    assign advance   = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || out_free;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = drive_reg;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_p_reg         <= '0;
            gain_i_reg         <= '0;
            gain_d_reg         <= '0;
            output_limit_reg   <= '0;
            integral_limit_reg <= '0;
            separation_on_reg  <= 1'b0;
            separation_thr_reg <= '0;
            incremental_reg    <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            case (pidpi_pkg::cfg_idx_t'(cfg_index))
                pidpi_pkg::CFG_GAIN_P:         gain_p_reg <= cfg_data[15:0];
                pidpi_pkg::CFG_GAIN_I:         gain_i_reg <= cfg_data[15:0];
                pidpi_pkg::CFG_GAIN_D:         gain_d_reg <= cfg_data[15:0];
                pidpi_pkg::CFG_OUTPUT_LIMIT:   output_limit_reg <= cfg_data[30:0];
                pidpi_pkg::CFG_INTEGRAL_LIMIT: integral_limit_reg <= cfg_data[30:0];
                pidpi_pkg::CFG_SEPARATION_ON:  separation_on_reg <= cfg_data[0];
                pidpi_pkg::CFG_SEPARATION_THR: separation_thr_reg <= cfg_data[16:0];
                pidpi_pkg::CFG_INCREMENTAL:    incremental_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_func_reg     <= s_tuser;
            in_setpoint_reg <= s_tdata[SW-1:0];
            in_measured_reg <= s_tdata[2*SW-1:SW];
        end
    end

    // error and its differences
    logic signed [EW-1:0]  err;
    logic [EW-1:0]         err_mag;
    logic signed [DW-1:0]  diff1;
    logic signed [D2W-1:0] diff2;

    assign err     = EW'(in_setpoint_reg) - EW'(in_measured_reg);
    assign err_mag = err[EW-1] ? EW'(-err) : EW'(err);
    assign diff1   = DW'(err) - DW'(last_err_reg);
    assign diff2   = D2W'(err) - (D2W'(last_err_reg) <<< 1) + D2W'(older_err_reg);

    // integral with separation and symmetric clamp
    logic                    integrate;
    logic signed [SUMW:0]    sum_raw;
    logic signed [SUMW:0]    ilim_pos, ilim_neg;
    logic signed [SUMW-1:0]  sum_clamped;

    assign integrate = !separation_on_reg ||
                       (CW'(err_mag) < CW'(separation_thr_reg));
    assign sum_raw   = (SUMW+1)'(err_sum_reg) + (integrate ? (SUMW+1)'(err) : '0);
    assign ilim_pos  = $signed({2'b00, integral_limit_reg});
    assign ilim_neg  = -ilim_pos;

    always_comb begin
        if (sum_raw > ilim_pos) begin
            sum_clamped = ilim_pos[SUMW-1:0];
        end else if (sum_raw < ilim_neg) begin
            sum_clamped = ilim_neg[SUMW-1:0];
        end else begin
            sum_clamped = sum_raw[SUMW-1:0];
        end
    end

    // multiplier operands by mode
    logic signed [OPW-1:0] op_p, op_i, op_d;

    always_comb begin
        if (incremental_reg) begin
            op_p = OPW'(diff1);
            op_i = OPW'(err);
            op_d = OPW'(diff2);
        end else begin
            op_p = OPW'(err);
            op_i = OPW'(sum_clamped);
            op_d = OPW'(diff1);
        end
    end

    // weighted sum and scaling
    logic signed [PW-1:0]   prod_p, prod_i, prod_d;
    logic signed [ACCW-1:0] acc, scaled;

    assign prod_p = gain_p_reg * op_p;
    assign prod_i = gain_i_reg * op_i;
    assign prod_d = gain_d_reg * op_d;
    assign acc    = ACCW'(prod_p) + ACCW'(prod_i) + ACCW'(prod_d);
    assign scaled = acc >>> GAIN_FRAC_BITS;

    // output clamp: limit in positional mode, 32-bit saturation in incremental
    logic signed [ACCW-1:0] lim_pos, lim_neg;

    always_comb begin
        if (incremental_reg) begin
            lim_pos = ACCW'({1'b0, {(pidpi_pkg::DRIVE_WIDTH-1){1'b1}}});
            lim_neg = -lim_pos - ACCW'(1);
        end else begin
            lim_pos = ACCW'({1'b0, output_limit_reg});
            lim_neg = -lim_pos;
        end
    end

    // result and state update
    always_comb begin
        last_err_next  = last_err_reg;
        older_err_next = older_err_reg;
        err_sum_next   = err_sum_reg;
        if (in_func_reg == pidpi_pkg::FUNC_CLEAR) begin
            drive_next     = '0;
            last_err_next  = '0;
            older_err_next = '0;
            err_sum_next   = '0;
        end else begin
            if (scaled > lim_pos) begin
                drive_next = lim_pos[pidpi_pkg::DRIVE_WIDTH-1:0];
            end else if (scaled < lim_neg) begin
                drive_next = lim_neg[pidpi_pkg::DRIVE_WIDTH-1:0];
            end else begin
                drive_next = scaled[pidpi_pkg::DRIVE_WIDTH-1:0];
            end
            last_err_next = err;
            if (incremental_reg) begin
                older_err_next = last_err_reg;
            end else begin
                err_sum_next = sum_clamped;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_err_reg  <= '0;
            older_err_reg <= '0;
            err_sum_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                last_err_reg  <= last_err_next;
                older_err_reg <= older_err_next;
                err_sum_reg   <= err_sum_next;
            end
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            drive_reg <= drive_next;
        end
    end

    // checks
    `ASSERT_NEXT(a_clear_zeroes, advance && in_func_reg == pidpi_pkg::FUNC_CLEAR,
        drive_reg == '0 && err_sum_reg == '0 && last_err_reg == '0 && older_err_reg == '0,
        "clear beat did not zero result and state")
    `ASSERT_NEXT(a_incr_history, advance && incremental_reg &&
        in_func_reg == pidpi_pkg::FUNC_STEP,
        older_err_reg == $past(last_err_reg) && err_sum_reg == $past(err_sum_reg),
        "incremental step did not shift history or touched integral")
    `ASSERT_NEXT(a_pos_limit, advance && !incremental_reg &&
        in_func_reg == pidpi_pkg::FUNC_STEP,
        $signed({drive_reg[31], drive_reg}) <= $signed({2'b00, $past(output_limit_reg)}) &&
        $signed({drive_reg[31], drive_reg}) >= -$signed({2'b00, $past(output_limit_reg)}),
        "positional drive outside output limit")
    `ASSERT_ALWAYS(a_ready_when_empty, !out_valid_reg |-> s_tready,
        "input stalled while result register empty")

endmodule

`default_nettype wire

/* bench/pid_drive_checker.sv */
// ----------------------------------------------------------------------------
// pid_drive_checker
// Watches the sample, drive and configuration channels of the PID unit,
// keeps its own copy of gains, limits, error history and integral, and
// compares every drive beat against the predicted value in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pid_drive_checker
    import pidpi_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    input  logic                      s_tready,
    // [15:0] setpoint, [31:16] measured
    input  logic [31:0]               s_tdata,
    // [0] func
    input  logic                      s_tuser,
    input  logic                      m_tvalid,
    input  logic                      m_tready,
    // [31:0] drive
    input  logic [DRIVE_WIDTH-1:0]    m_tdata,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [CFG_IDX_WIDTH-1:0]  cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0] cfg_data,
    output int                        failures,
    output int                        outstanding
);

    localparam int SAMPLE_W  = 16;
    localparam int FRAC_BITS = 8;

    // shadow of the configuration registers
    logic signed [GAIN_WIDTH-1:0] kp, ki, kd;
    logic [LIMIT_WIDTH-1:0]       out_lim, int_lim;
    logic                         sep_en;
    logic [THRESH_WIDTH-1:0]      sep_thr;
    logic                         incr_mode;

    // controller history
    logic signed [16:0]           err_last, err_older;
    logic signed [31:0]           integ;

    logic [DRIVE_WIDTH-1:0]       drive_q[$];
    int                           fail_count = 0;

    function automatic longint clamp_sym(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // one controller step; updates the history and returns the drive
    function automatic logic [DRIVE_WIDTH-1:0] predict_drive(func_t f,
                                                             logic signed [SAMPLE_W-1:0] sp,
                                                             logic signed [SAMPLE_W-1:0] ms);
        longint e, mag, sum, acc, res;
        if (f == FUNC_CLEAR) begin
            err_last  = '0;
            err_older = '0;
            integ     = '0;
            return '0;
        end
        e = longint'(sp) - longint'(ms);
        if (!incr_mode) begin
            // integrate unless separation blocks a large error
            mag = (e < 0) ? -e : e;
            sum = longint'(integ);
            if (!sep_en || mag < longint'(sep_thr))
                sum = sum + e;
            sum = clamp_sym(sum, longint'(int_lim));
            acc = longint'(kp) * e + longint'(ki) * sum
                + longint'(kd) * (e - longint'(err_last));
            res = clamp_sym(acc >>> FRAC_BITS, longint'(out_lim));
            integ    = 32'(sum);
            err_last = 17'(e);
        end else begin
            // delta form, saturated to 32 bits
            acc = longint'(kp) * (e - longint'(err_last)) + longint'(ki) * e
                + longint'(kd) * (e - 2 * longint'(err_last) + longint'(err_older));
            res = acc >>> FRAC_BITS;
            if (res > longint'(32'sh7fffffff)) res = longint'(32'sh7fffffff);
            if (res < longint'(32'sh80000000)) res = longint'(32'sh80000000);
            err_older = err_last;
            err_last  = 17'(e);
        end
        return res[DRIVE_WIDTH-1:0];
    endfunction

    // track config writes, predict on sample beats, compare on drive beats
    always @(posedge aclk) begin
        logic [DRIVE_WIDTH-1:0] want;
        if (!aresetn) begin
            kp        = '0;
            ki        = '0;
            kd        = '0;
            out_lim   = '0;
            int_lim   = '0;
            sep_en    = 1'b0;
            sep_thr   = '0;
            incr_mode = 1'b0;
            err_last  = '0;
            err_older = '0;
            integ     = '0;
            drive_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_GAIN_P:         kp        = cfg_data[GAIN_WIDTH-1:0];
                    CFG_GAIN_I:         ki        = cfg_data[GAIN_WIDTH-1:0];
                    CFG_GAIN_D:         kd        = cfg_data[GAIN_WIDTH-1:0];
                    CFG_OUTPUT_LIMIT:   out_lim   = cfg_data[LIMIT_WIDTH-1:0];
                    CFG_INTEGRAL_LIMIT: int_lim   = cfg_data[LIMIT_WIDTH-1:0];
                    CFG_SEPARATION_ON:  sep_en    = cfg_data[0];
                    CFG_SEPARATION_THR: sep_thr   = cfg_data[THRESH_WIDTH-1:0];
                    CFG_INCREMENTAL:    incr_mode = cfg_data[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                drive_q.push_back(predict_drive(func_t'(s_tuser),
                                                s_tdata[SAMPLE_W-1:0],
                                                s_tdata[2*SAMPLE_W-1:SAMPLE_W]));
            if (m_tvalid && m_tready) begin
                if (drive_q.size() == 0) begin
                    $error("drive beat with no expectation waiting: actual %0d",
                           $signed(m_tdata));
                    fail_count++;
                end else begin
                    want = drive_q.pop_front();
                    if (m_tdata !== want) begin
                        $error("drive mismatch: expected %0d, actual %0d",
                               $signed(want), $signed(m_tdata));
                        fail_count++;
                    end
                end
            end
        end
        failures    <= fail_count;
        outstanding <= drive_q.size();
    end

endmodule

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the positional / incremental PID unit: a directed pass over
// field and gain extremes, both modes, clears, separation and zero limits,
// then random control loops under changing configuration and back-pressure.
// A separate checker predicts every drive beat and counts mismatches.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import pidpi_pkg::*;

    localparam int SEGMENTS     = 12;
    localparam int SEG_BEATS    = 140;
    localparam int HOLD_CYCLES  = 100;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    // [15:0] setpoint, [31:16] measured
    logic [31:0] s_tdata   = '0;
    // [0] func
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    // [31:0] drive
    logic [DRIVE_WIDTH-1:0]    m_tdata;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_IDX_WIDTH-1:0]  cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0] cfg_data  = '0;

    int   failures;
    int   outstanding;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    logic m_hold        = 1'b0;
    int   plant_target  = 0;
    int   plant_value   = 0;

    pid_position_incremental_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pid_drive_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .failures    (failures),
        .outstanding (outstanding)
    );

    always #5 aclk = ~aclk;

    // result side back-pressure
    always @(posedge aclk) begin
        if (!aresetn || m_hold)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // offer one sample beat, with random gaps ahead of it
    task automatic send_beat(func_t f, logic [15:0] sp, logic [15:0] ms);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= {ms, sp};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // stop offering and wait until every drive beat has come back
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    task automatic reg_write(cfg_idx_t idx, logic [CFG_DATA_WIDTH-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic apply_config(logic [15:0] gp, logic [15:0] gi, logic [15:0] gd,
                                logic [30:0] olim, logic [30:0] ilim,
                                logic sep, logic [16:0] thr, logic incr);
        wait_idle();
        reg_write(CFG_GAIN_P,         {{16{gp[15]}}, gp});
        reg_write(CFG_GAIN_I,         {{16{gi[15]}}, gi});
        reg_write(CFG_GAIN_D,         {{16{gd[15]}}, gd});
        reg_write(CFG_OUTPUT_LIMIT,   {1'b0, olim});
        reg_write(CFG_INTEGRAL_LIMIT, {1'b0, ilim});
        reg_write(CFG_SEPARATION_ON,  {31'b0, sep});
        reg_write(CFG_SEPARATION_THR, {15'b0, thr});
        reg_write(CFG_INCREMENTAL,    {31'b0, incr});
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] pick_gain();
        int v;
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: return $urandom_range(1) ? 16'h8000 : 16'h7fff;
            default: begin
                v = $urandom_range(2048);
                v = v - 1024;
                return 16'(v);
            end
        endcase
    endfunction

    function automatic logic [30:0] pick_limit();
        case ($urandom_range(4))
            0: return '0;
            1: return 31'($urandom_range(4096));
            2: return 31'h7fffffff;
            default: return 31'($urandom);
        endcase
    endfunction

    function automatic logic [16:0] pick_threshold();
        case ($urandom_range(3))
            0: return '0;
            1: return 17'd65536;
            2: return 17'($urandom_range(65536));
            default: return 17'($urandom_range(2000, 1));
        endcase
    endfunction

    task automatic random_config();
        apply_config(pick_gain(), pick_gain(), pick_gain(), pick_limit(), pick_limit(),
                     1'($urandom_range(1)), pick_threshold(), 1'($urandom_range(1)));
    endtask

    // mostly a plant settling toward a target, plus raw samples and clears
    task automatic random_beat();
        int r, noise;
        r = $urandom_range(99);
        if (r < 5) begin
            send_beat(FUNC_CLEAR, 16'($urandom), 16'($urandom));
        end else if (r < 30) begin
            send_beat(FUNC_STEP, 16'($urandom), 16'($urandom));
        end else begin
            if ($urandom_range(9) == 0) begin
                plant_target = $urandom_range(65535);
                plant_target = plant_target - 32768;
            end
            noise = $urandom_range(64);
            noise = noise - 32;
            plant_value = plant_value + (plant_target - plant_value) / 4 + noise;
            if (plant_value > 32767) plant_value = 32767;
            if (plant_value < -32768) plant_value = -32768;
            send_beat(FUNC_STEP, 16'(plant_target), 16'(plant_value));
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn       <= 1'b1;
        send_idle_pct = 33;
        recv_idle_pct <= 73;

        // positional, unit proportional gain, no clamping in reach
        apply_config(16'd256, 16'd128, 16'hfe00, 31'h7fffffff, 31'h7fffffff,
                     1'b0, 17'd0, 1'b0);
        send_beat(FUNC_STEP, 16'h7fff, 16'h8000);
        send_beat(FUNC_STEP, 16'h8000, 16'h7fff);
        send_beat(FUNC_STEP, 16'h0000, 16'h0000);
        send_beat(FUNC_STEP, 16'hffff, 16'h0000);
        send_beat(FUNC_STEP, 16'd5, 16'd3);
        send_beat(FUNC_CLEAR, 16'h7fff, 16'h8000);
        send_beat(FUNC_STEP, 16'd100, 16'hff9c);

        // extreme gains, integral held at zero
        apply_config(16'h7fff, 16'h8000, 16'h7fff, 31'd1000, 31'd0, 1'b0, 17'd0, 1'b0);
        send_beat(FUNC_STEP, 16'h7fff, 16'h8000);
        send_beat(FUNC_STEP, 16'h8000, 16'h7fff);
        send_beat(FUNC_STEP, 16'd1, 16'd0);

        // zero output limit, separation with zero threshold
        apply_config(16'h8000, 16'h7fff, 16'h8000, 31'd0, 31'h7fffffff,
                     1'b1, 17'd0, 1'b0);
        send_beat(FUNC_STEP, 16'd1000, 16'd0);
        send_beat(FUNC_STEP, 16'hfc18, 16'd0);

        // widest threshold, small integral limit
        apply_config(16'd64, 16'h7fff, 16'd32, 31'h7fffffff, 31'd300,
                     1'b1, 17'd65536, 1'b0);
        send_beat(FUNC_STEP, 16'h7fff, 16'h8000);
        send_beat(FUNC_STEP, 16'd100, 16'd0);
        send_beat(FUNC_STEP, 16'd200, 16'd0);

        // incremental form at full gain
        apply_config(16'h7fff, 16'h7fff, 16'h7fff, 31'd0, 31'd0, 1'b0, 17'd0, 1'b1);
        send_beat(FUNC_STEP, 16'h7fff, 16'h8000);
        send_beat(FUNC_STEP, 16'h8000, 16'h7fff);
        send_beat(FUNC_STEP, 16'h7fff, 16'h8000);
        send_beat(FUNC_CLEAR, 16'h0000, 16'h0000);
        send_beat(FUNC_STEP, 16'hfffd, 16'h0000);

        // random control loops, idling pattern switches by thirds
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            if (seg == SEGMENTS / 3) begin
                send_idle_pct = 73;
                recv_idle_pct <= 33;
            end
            if (seg == 2 * SEGMENTS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct <= 0;
            end
            random_config();
            // receiver holds off while the sender keeps offering
            if (seg == 2 * SEGMENTS / 3) begin
                fork
                    begin
                        m_hold <= 1'b1;
                        repeat (HOLD_CYCLES) @(posedge aclk);
                        m_hold <= 1'b0;
                    end
                join_none
            end
            for (int i = 0; i < SEG_BEATS; i++) begin
                if (seg == SEGMENTS / 3 + 1 && i == SEG_BEATS / 2)
                    wait_idle();
                random_beat();
            end
        end

        wait_idle();
        repeat (4) @(posedge aclk);
        if (failures == 0 && outstanding == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/pidpi_pkg.sv
rtl/core/pid_position_incremental_unit.sv
bench/pid_drive_checker.sv
bench/tb_top.sv
